// File: hdl/match_position_to_node_mapper_unit_macros.svh
// Assertion macros for the match position to node mapper
`ifndef MATCH_POSITION_TO_NODE_MAPPER_UNIT_MACROS_SVH
`define MATCH_POSITION_TO_NODE_MAPPER_UNIT_MACROS_SVH

// Check a same-cycle implication on the rising clock edge
`define MMAP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check an implication on the next cycle
`define MMAP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/mmap_pkg.sv
`default_nettype none
package mmap_pkg;

    // Field widths
    localparam int unsigned IDENT_W = 31;
    localparam int unsigned LEN_W   = 24;
    localparam int unsigned POS_W   = 32;
    localparam int unsigned MLEN_W  = 20;
    localparam int unsigned QPOS_W  = 20;
    localparam int unsigned STAT_W  = 2;

    // Command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_OUTSIDE = 2'd1;
    localparam logic [STAT_W-1:0] ST_CROSSES = 2'd2;

    // Search sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_SPAN,
        S_FINISH
    } t_state;

    // Query word handed to the search unit
    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [MLEN_W-1:0] mlen;
        logic              fwd;
        logic [QPOS_W-1:0] qpos;
    } t_query;

    // Result word
    typedef struct packed {
        logic [IDENT_W-1:0] ident;
        logic [LEN_W-1:0]   offset;
        logic [QPOS_W-1:0]  read_pos;
        logic [MLEN_W-1:0]  seed_len;
        logic               reverse;
        logic [STAT_W-1:0]  status;
    } t_result;

endpackage
`default_nettype wire

// File: hdl/mmap_ram.sv
`default_nettype none
module mmap_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one entry, register the read word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: hdl/mmap_search.sv
`default_nettype none
module mmap_search #(
    parameter int unsigned MAX_NODES = 4096
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_go,
    input  wire mmap_pkg::t_query                 i_query,
    input  wire logic [$clog2(MAX_NODES+1)-1:0]   i_count,
    input  wire logic [mmap_pkg::POS_W-1:0]       i_text_end,
    input  wire logic [mmap_pkg::POS_W-1:0]       i_start_rd,
    input  wire logic [mmap_pkg::IDENT_W-1:0]     i_ident_rd,
    output logic      [$clog2(MAX_NODES)-1:0]     o_rd_addr,
    output logic                                  o_busy,
    output logic                                  o_valid,
    output mmap_pkg::t_result                     o_result
);
    import mmap_pkg::*;

    localparam int unsigned AW = $clog2(MAX_NODES);
    localparam int unsigned CW = $clog2(MAX_NODES + 1);

    t_state             r_state, n_state;
    t_query             r_query, n_query;
    logic [CW-1:0]      r_lo, n_lo;
    logic [CW-1:0]      r_hi, n_hi;
    logic [CW-1:0]      r_mid, n_mid;
    logic [POS_W-1:0]   r_lo_start, n_lo_start;
    logic [POS_W-1:0]   r_hi_start, n_hi_start;
    logic [IDENT_W-1:0] r_lo_ident, n_lo_ident;
    logic [LEN_W-1:0]   r_off, n_off;
    logic [LEN_W-1:0]   r_nlen, n_nlen;
    logic               r_found, n_found;
    logic               r_valid, n_valid;
    t_result            r_result, n_result;

    logic [POS_W-1:0]   off_full;
    logic [POS_W-1:0]   nlen_full;
    logic [LEN_W:0]     match_end;

    // Span arithmetic on the bracketing starts
    assign off_full  = r_query.pos - r_lo_start;
    assign nlen_full = r_hi_start - r_lo_start - POS_W'(1);
    assign match_end = {1'b0, r_off} + (LEN_W+1)'(r_query.mlen);

    // Advance the sequencer, one table read per cycle while searching
    always_comb begin
        logic          le;
        logic [CW-1:0] lo_nx;
        logic [CW-1:0] hi_nx;

        n_state    = r_state;
        n_query    = r_query;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_mid      = r_mid;
        n_lo_start = r_lo_start;
        n_hi_start = r_hi_start;
        n_lo_ident = r_lo_ident;
        n_off      = r_off;
        n_nlen     = r_nlen;
        n_found    = r_found;
        n_valid    = 1'b0;
        n_result   = r_result;
        o_rd_addr  = r_mid[AW-1:0];
        le         = 1'b0;
        lo_nx      = r_lo;
        hi_nx      = r_hi;

        unique case (r_state)
            S_IDLE: begin
                n_mid     = i_count >> 1;
                o_rd_addr = n_mid[AW-1:0];
                if (i_go) begin
                    n_query = i_query;
                    if (i_count == '0 || i_query.pos >= i_text_end) begin
                        n_valid           = 1'b1;
                        n_result.ident    = '0;
                        n_result.offset   = '0;
                        n_result.read_pos = i_query.qpos;
                        n_result.seed_len = i_query.mlen;
                        n_result.reverse  = ~i_query.fwd;
                        n_result.status   = ST_OUTSIDE;
                    end else begin
                        n_lo       = '0;
                        n_hi       = i_count;
                        n_hi_start = i_text_end;
                        n_lo_start = '0;
                        n_lo_ident = '0;
                        n_state    = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                // Narrow the bracket on the word read at the last midpoint
                le = (i_start_rd <= r_query.pos);
                if (le) begin
                    lo_nx      = r_mid + CW'(1);
                    n_lo_start = i_start_rd;
                    n_lo_ident = i_ident_rd;
                end else begin
                    hi_nx      = r_mid;
                    n_hi_start = i_start_rd;
                end
                n_lo  = lo_nx;
                n_hi  = hi_nx;
                n_mid = lo_nx + ((hi_nx - lo_nx) >> 1);
                o_rd_addr = n_mid[AW-1:0];
                if (!(lo_nx < hi_nx)) begin
                    n_state = S_SPAN;
                end
            end
            S_SPAN: begin
                n_off   = off_full[LEN_W-1:0];
                n_nlen  = nlen_full[LEN_W-1:0];
                n_found = (r_lo != '0);
                n_state = S_FINISH;
            end
            S_FINISH: begin
                n_valid           = 1'b1;
                n_result.read_pos = r_query.qpos;
                n_result.seed_len = r_query.mlen;
                n_result.reverse  = ~r_query.fwd;
                n_result.ident    = r_found ? r_lo_ident : '0;
                n_result.offset   = '0;
                if (!r_found) begin
                    n_result.status = ST_OUTSIDE;
                end else if (match_end > {1'b0, r_nlen}) begin
                    n_result.status = ST_CROSSES;
                end else begin
                    n_result.status = ST_OK;
                    n_result.offset = r_query.fwd ? r_off
                                                  : r_nlen - match_end[LEN_W-1:0];
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    // Hold search and result payload
    always_ff @(posedge i_clk) begin
        r_query    <= n_query;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_mid      <= n_mid;
        r_lo_start <= n_lo_start;
        r_hi_start <= n_hi_start;
        r_lo_ident <= n_lo_ident;
        r_off      <= n_off;
        r_nlen     <= n_nlen;
        r_found    <= n_found;
        r_result   <= n_result;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
`default_nettype wire

// File: hdl/match_position_to_node_mapper_unit.sv
// Maps a match position in the concatenated reference text to a node and
// an offset. A load word (command 0) is taken and gives no result; a full
// table drops it. A query word (command 1) gives exactly one result word,
// shown for one cycle with o_valid high; the receiver cannot stall, so it
// must take every word as it comes. A query outside the text answers on
// the next cycle and keeps busy low. Any other query runs a binary search
// of at most S = floor(log2(node_count)) + 1 steps, with one start-table
// read per cycle; busy stays high through the search and the span and
// finish states, and the result word shows in the first cycle with busy
// low again. The start table has a single read port, so each search step
// reads one midpoint.
`default_nettype none
`include "match_position_to_node_mapper_unit_macros.svh"
module match_position_to_node_mapper_unit #(
    parameter int unsigned MAX_NODES = 4096
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_command,
    input  wire logic [mmap_pkg::IDENT_W-1:0]  i_node_ident,
    input  wire logic [mmap_pkg::LEN_W-1:0]    i_node_len,
    input  wire logic [mmap_pkg::POS_W-1:0]    i_ref_position,
    input  wire logic [mmap_pkg::MLEN_W-1:0]   i_match_length,
    input  wire logic                          i_forward,
    input  wire logic [mmap_pkg::QPOS_W-1:0]   i_query_position,
    output logic                               o_valid,
    output logic      [mmap_pkg::IDENT_W-1:0]  o_hit_node_ident,
    output logic      [mmap_pkg::LEN_W-1:0]    o_node_offset,
    output logic      [mmap_pkg::QPOS_W-1:0]   o_read_position,
    output logic      [mmap_pkg::MLEN_W-1:0]   o_seed_length,
    output logic                               o_reverse,
    output logic      [mmap_pkg::STAT_W-1:0]   o_status
);
    import mmap_pkg::*;

    localparam int unsigned AW = $clog2(MAX_NODES);
    localparam int unsigned CW = $clog2(MAX_NODES + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_NODES);

    logic [CW-1:0]      r_count, n_count;
    logic [POS_W-1:0]   r_text_end, n_text_end;
    logic               accept;
    logic               load_we;
    logic               query_go;
    logic [POS_W:0]     end_sum;
    logic [AW-1:0]      rd_addr;
    logic [POS_W-1:0]   start_rd;
    logic [IDENT_W-1:0] ident_rd;
    t_query             query;
    t_result            result;

    assign accept   = start && !busy;
    assign load_we  = accept && (i_command == CMD_LOAD) && (r_count < MAX_CNT);
    assign query_go = accept && (i_command == CMD_QUERY);

    // Grow the text end by node length plus separator, saturating
    assign end_sum    = {1'b0, r_text_end} + (POS_W+1)'(i_node_len) + (POS_W+1)'(1);
    assign n_text_end = end_sum[POS_W] ? {POS_W{1'b1}} : end_sum[POS_W-1:0];
    assign n_count    = r_count + CW'(1);

    // Hold table fill state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_text_end <= '0;
        end else if (load_we) begin
            r_count    <= n_count;
            r_text_end <= n_text_end;
        end
    end

    // Node start table
    mmap_ram #(
        .WIDTH (POS_W),
        .DEPTH (MAX_NODES)
    ) u_start_ram (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_text_end),
        .i_raddr (rd_addr),
        .o_rdata (start_rd)
    );

    // Node identifier table
    mmap_ram #(
        .WIDTH (IDENT_W),
        .DEPTH (MAX_NODES)
    ) u_ident_ram (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_node_ident),
        .i_raddr (rd_addr),
        .o_rdata (ident_rd)
    );

    assign query.pos  = i_ref_position;
    assign query.mlen = i_match_length;
    assign query.fwd  = i_forward;
    assign query.qpos = i_query_position;

    // Search sequencer and result register
    mmap_search #(
        .MAX_NODES (MAX_NODES)
    ) u_search (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (query_go),
        .i_query    (query),
        .i_count    (r_count),
        .i_text_end (r_text_end),
        .i_start_rd (start_rd),
        .i_ident_rd (ident_rd),
        .o_rd_addr  (rd_addr),
        .o_busy     (busy),
        .o_valid    (o_valid),
        .o_result   (result)
    );

    assign o_hit_node_ident = result.ident;
    assign o_node_offset    = result.offset;
    assign o_read_position  = result.read_pos;
    assign o_seed_length    = result.seed_len;
    assign o_reverse        = result.reverse;
    assign o_status         = result.status;

    // Checks
    `MMAP_ASSERT_NOW(a_valid_idle, o_valid, !busy, "result word while search busy")
    `MMAP_ASSERT_NEXT(a_load_silent, accept && i_command == CMD_LOAD, !o_valid, "load gave a result")
    `MMAP_ASSERT_NOW(a_outside_zero, o_valid && o_status == ST_OUTSIDE, o_hit_node_ident == '0 && o_node_offset == '0, "outside result not cleared")
    `MMAP_ASSERT_NOW(a_count_cap, 1'b1, r_count <= MAX_CNT, "node count past capacity")

endmodule
`default_nettype wire
